[hw/rtl/f16cobs_pkg.sv]
// shared types, constants and the mod-255 fold for the fletcher-16 / cobs frame encoder
// no dependencies; imported by fletcher16_cobs_frame_encoder_top, f16cobs_frame_checker and tb
package f16cobs_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int PACKET_BYTES  = 10;
    localparam int COBS_BYTES    = PACKET_BYTES + 1;
    localparam int FRAME_BYTES   = COBS_BYTES + 1;
    localparam int CNT_W         = $clog2(FRAME_BYTES);

    localparam logic [7:0] FRAME_DELIM = 8'h00;
    localparam logic [8:0] MOD_BASE    = 9'd255;

    localparam logic [CNT_W-1:0] LAST_BEAT = CNT_W'(FRAME_BYTES - 1);

    typedef logic [7:0] byte_t;
    typedef byte_t [PACKET_BYTES-1:0] packet_t;
    typedef byte_t [COBS_BYTES-1:0]   cobs_t;
    typedef byte_t [FRAME_BYTES-1:0]  frame_t;

    // 256 = 1 mod 255, so fold the high part onto the low byte, then one correction
    function automatic byte_t mod255(input logic [13:0] v);
        logic [8:0] folded;
        folded = 9'(v[13:8]) + 9'(v[7:0]);
        if (folded >= MOD_BASE) begin
            folded = folded - MOD_BASE;
        end
        return folded[7:0];
    endfunction

endpackage

[hw/rtl/fletcher16_cobs_frame_encoder_top.sv]
// fletcher-16 checked, cobs framed step-command encoder
// depends on f16cobs_pkg for packet types, frame constants and the mod-255 fold

// Each accepted beat carries two signed 32-bit step counts (x in tdata[31:0], y in
// tdata[63:32]) and produces one 12-byte frame on the byte-wide output: a 0x00
// delimiter followed by the 11 cobs bytes of the little-endian payload plus its
// fletcher-16 checksum (sum1 then sum2), with tlast on the twelfth byte. Three
// register stages (raw sums, mod-255 reduction, cobs encoding) feed a frame
// buffer, which takes a new frame when it is empty or as the last byte of the
// previous frame is taken. The output serializer moves one byte per cycle while
// m_axis_tready is high; up to three further commands are taken into the
// pipeline while a frame is still being sent. No state is kept between commands.
module fletcher16_cobs_frame_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] x_steps, [63:32] y_steps
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
    output logic        m_axis_tlast
);
    import f16cobs_pkg::*;

    // stage 1: payload bytes and unreduced fletcher sums
    logic        s1_valid_reg, s1_valid_next;
    logic [63:0] s1_data_reg;
    logic [10:0] s1_sum1_reg, s1_sum1_next;
    logic [13:0] s1_sum2_reg, s1_sum2_next;

    // stage 2: full 10-byte packet
    logic        s2_valid_reg, s2_valid_next;
    packet_t     s2_pkt_reg, s2_pkt_next;

    // stage 3: cobs bytes
    logic        s3_valid_reg, s3_valid_next;
    cobs_t       s3_enc_reg, s3_enc_next;

    // output frame buffer
    logic             ser_valid_reg, ser_valid_next;
    logic [CNT_W-1:0] ser_cnt_reg, ser_cnt_next;
    frame_t           ser_buf_reg;

    logic s1_ready, s2_ready, s3_ready;
    logic ser_done, ser_load;

    // handshake chain, back to front
    assign ser_done = ser_valid_reg && m_axis_tready && (ser_cnt_reg == LAST_BEAT);
    assign ser_load = s3_valid_reg && (!ser_valid_reg || ser_done);
    assign s3_ready = !s3_valid_reg || ser_load;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign s_axis_tready = s1_ready;

    assign s1_valid_next = s1_ready ? s_axis_tvalid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg  : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg  : s3_valid_reg;

    // sum1 is the plain byte sum; sum2 weights byte i by (8 - i)
    always_comb begin
        byte_t b;
        s1_sum1_next = '0;
        s1_sum2_next = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            b = s_axis_tdata[8*i +: 8];
            s1_sum1_next = s1_sum1_next + 11'(b);
            s1_sum2_next = s1_sum2_next + 14'(b) * 14'(PAYLOAD_BYTES - i);
        end
    end

    always_comb begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            s2_pkt_next[i] = s1_data_reg[8*i +: 8];
        end
        s2_pkt_next[PAYLOAD_BYTES]     = mod255(14'(s1_sum1_reg));
        s2_pkt_next[PAYLOAD_BYTES + 1] = mod255(s1_sum2_reg);
    end

    // each code position holds the distance to the next zero byte or the packet end
    always_comb begin
        logic [PACKET_BYTES-1:0] is_zero;
        byte_t                   code;
        for (int p = 0; p < PACKET_BYTES; p++) begin
            is_zero[p] = (s2_pkt_reg[p] == 8'h00);
        end
        for (int q = 0; q < COBS_BYTES; q++) begin
            code = 8'(COBS_BYTES - q);
            for (int j = PACKET_BYTES - 1; j >= 0; j--) begin
                if (j >= q && is_zero[j]) begin
                    code = 8'(j - q + 1);
                end
            end
            if (q == 0) begin
                s3_enc_next[q] = code;
            end else if (is_zero[q-1]) begin
                s3_enc_next[q] = code;
            end else begin
                s3_enc_next[q] = s2_pkt_reg[q-1];
            end
        end
    end

    always_comb begin
        ser_valid_next = ser_valid_reg;
        ser_cnt_next   = ser_cnt_reg;
        if (ser_load) begin
            ser_valid_next = 1'b1;
            ser_cnt_next   = '0;
        end else if (ser_valid_reg && m_axis_tready) begin
            if (ser_cnt_reg == LAST_BEAT) begin
                ser_valid_next = 1'b0;
            end else begin
                ser_cnt_next = ser_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            ser_valid_reg <= ser_valid_next;
            ser_cnt_reg   <= ser_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_data_reg <= s_axis_tdata;
            s1_sum1_reg <= s1_sum1_next;
            s1_sum2_reg <= s1_sum2_next;
        end
        if (s2_ready) begin
            s2_pkt_reg <= s2_pkt_next;
        end
        if (s3_ready) begin
            s3_enc_reg <= s3_enc_next;
        end
        if (ser_load) begin
            ser_buf_reg <= {s3_enc_reg, FRAME_DELIM};
        end
    end

    assign m_axis_tvalid = ser_valid_reg;
    assign m_axis_tdata  = ser_buf_reg[ser_cnt_reg];
    assign m_axis_tlast  = (ser_cnt_reg == LAST_BEAT);

`ifndef SYNTHESIS
    // cobs output never carries a zero byte
    a_cobs_no_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (s3_enc_reg[0] != 8'h00 && s3_enc_reg[1] != 8'h00
            && s3_enc_reg[2] != 8'h00 && s3_enc_reg[3] != 8'h00
            && s3_enc_reg[4] != 8'h00 && s3_enc_reg[5] != 8'h00
            && s3_enc_reg[6] != 8'h00 && s3_enc_reg[7] != 8'h00
            && s3_enc_reg[8] != 8'h00 && s3_enc_reg[9] != 8'h00
            && s3_enc_reg[10] != 8'h00))
        else $error("zero byte in cobs stage");

    // reduced checksums stay below 255
    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> (s2_pkt_reg[PAYLOAD_BYTES] != 8'hFF
            && s2_pkt_reg[PAYLOAD_BYTES + 1] != 8'hFF))
        else $error("checksum not reduced mod 255");

    // every frame opens with the delimiter
    a_delim_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (ser_valid_reg && ser_cnt_reg == '0) |-> (m_axis_tdata == FRAME_DELIM))
        else $error("frame does not start with delimiter");

    // the beat counter never runs past the frame
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg |-> (ser_cnt_reg <= LAST_BEAT))
        else $error("frame counter out of range");

    // the last beat with nothing queued behind it leaves the output idle
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (ser_done && !s3_valid_reg) |=> !m_axis_tvalid)
        else $error("output still valid after last beat");
`endif

endmodule

[test/f16cobs_frame_checker.sv]
// frame checker for fletcher16_cobs_frame_encoder_top: predicts the 12-byte frame of every
// accepted command and compares each output beat against it in order
// depends on f16cobs_pkg for byte and frame types and the frame constants
module f16cobs_frame_checker
    import f16cobs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] x_steps, [63:32] y_steps
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
    input  logic        m_axis_tlast,
    output int          mismatch_count,
    output int          beats_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        byte_t data;
        logic  last;
    } frame_beat_t;

    frame_beat_t expected_beats[$];
    int          reported;

    // payload bytes little-endian, fletcher-16 sums, then cobs with the delimiter in front
    function automatic frame_t frame_of_steps(input logic [31:0] x, input logic [31:0] y);
        byte_t  pkt[PACKET_BYTES];
        byte_t  enc[COBS_BYTES];
        frame_t fr;
        int     s1;
        int     s2;
        int     code_pos;
        int     wr;
        byte_t  code;
        for (int i = 0; i < 4; i++) begin
            pkt[i]     = x[8*i +: 8];
            pkt[4 + i] = y[8*i +: 8];
        end
        s1 = 0;
        s2 = 0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            s1 = (s1 + pkt[i]) % 255;
            s2 = (s2 + s1) % 255;
        end
        pkt[8] = s1[7:0];
        pkt[9] = s2[7:0];
        // ten bytes never fill a 254-byte block, so only zero bytes close a block
        code_pos = 0;
        wr       = 1;
        code     = 8'd1;
        for (int i = 0; i < PACKET_BYTES; i++) begin
            if (pkt[i] == 8'h00) begin
                enc[code_pos] = code;
                code_pos      = wr;
                wr++;
                code = 8'd1;
            end else begin
                enc[wr] = pkt[i];
                wr++;
                code++;
            end
        end
        enc[code_pos] = code;
        fr[0] = FRAME_DELIM;
        for (int i = 0; i < COBS_BYTES; i++) begin
            fr[i + 1] = enc[i];
        end
        return fr;
    endfunction

    initial begin
        mismatch_count = 0;
        beats_pending  = 0;
        reported       = 0;
    end

    always @(posedge aclk) begin
        frame_t      fr;
        frame_beat_t want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                fr = frame_of_steps(s_axis_tdata[31:0], s_axis_tdata[63:32]);
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    expected_beats.push_back('{data: fr[i], last: (i == FRAME_BYTES - 1)});
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    mismatch_count++;
                    if (reported < 10) begin
                        reported++;
                        $display("[%0t] unexpected output beat: byte %02h last %b",
                                 $realtime, m_axis_tdata, m_axis_tlast);
                    end
                end else begin
                    want = expected_beats.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
                        mismatch_count++;
                        if (reported < 10) begin
                            reported++;
                            $display("[%0t] frame beat mismatch: expected byte %02h last %b,",
                                     $realtime, want.data, want.last,
                                     " got byte %02h last %b", m_axis_tdata, m_axis_tlast);
                        end
                    end
                end
            end
            beats_pending = expected_beats.size();
        end
    end

endmodule

[test/tb.sv]
// testbench top for fletcher16_cobs_frame_encoder_top: drives step commands in random bursts,
// stalls the byte output, and reports the verdict from f16cobs_frame_checker
// depends on f16cobs_pkg, the encoder rtl and test/f16cobs_frame_checker.sv
module tb;
    import f16cobs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CMDS = 210;
    localparam int CYCLE_LIMIT = 500000;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_SPARSE} rx_mode_e;
    typedef enum int {WORD_ANY, WORD_SPARSE, WORD_NEAR_ZERO, WORD_EDGE_BYTES} word_kind_e;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] x_steps, [63:32] y_steps
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] frame_byte
    logic        m_axis_tlast;

    int          mismatch_count;
    int          beats_pending;
    int          cycles;
    logic [63:0] step_cmds[$];

    fletcher16_cobs_frame_encoder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    f16cobs_frame_checker frame_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("fletcher16_cobs_frame_encoder_top verification failed");
            $finish;
        end
    end

    // step words biased toward zero bytes, 0xff bytes and small signed counts
    function automatic logic [31:0] step_word(input word_kind_e kind);
        logic [31:0] w;
        w = $urandom;
        case (kind)
            WORD_SPARSE: begin
                for (int i = 0; i < 4; i++) begin
                    if ($urandom_range(0, 1) == 0) w[8*i +: 8] = 8'h00;
                end
            end
            WORD_NEAR_ZERO: begin
                w = 32'($signed($urandom_range(0, 4095)) - 2048);
            end
            WORD_EDGE_BYTES: begin
                for (int i = 0; i < 4; i++) begin
                    case ($urandom_range(0, 2))
                        0: w[8*i +: 8] = 8'h00;
                        1: w[8*i +: 8] = 8'hFF;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_cmd(input logic [63:0] cmd);
        s_axis_tdata  <= cmd;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // receiver: stretches of different ready patterns
    initial begin
        rx_mode_e mode;
        int       len;
        m_axis_tready = 1'b0;
        forever begin
            mode = rx_mode_e'($urandom_range(0, 3));
            len  = $urandom_range(8, 48);
            repeat (len) begin
                @(negedge aclk);
                case (mode)
                    READY_ALWAYS: m_axis_tready <= 1'b1;
                    READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default:      m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin
        int idx;
        int burst;
        int gap;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // {y_steps, x_steps}
        step_cmds = '{
            {32'h0000_0000, 32'h0000_0000},
            {32'hFFFF_FFFF, 32'hFFFF_FFFF},   // all 0xff bytes: checksum folds to zero
            {32'h8000_0000, 32'h7FFF_FFFF},
            {32'h7FFF_FFFF, 32'h8000_0000},
            {32'hFFFF_FFFF, 32'h0000_0001},
            {32'h0000_0000, 32'h0000_0001},
            {32'hFF00_FF00, 32'h00FF_00FF},
            {32'h0101_0101, 32'h0101_0101},
            {32'h9ABC_DEF0, 32'h1234_5678},
            {32'h0001_0000, 32'h0000_0100},
            {32'h0000_00FF, 32'hFF00_0000},
            {32'h0000_0000, 32'h0000_00FF},   // sum1 reaches 255 and wraps, both checksum bytes zero
            {32'hFEFE_FEFE, 32'hFEFE_FEFE},
            {32'h0000_0080, 32'h0000_007F},
            {32'hCAFE_F00D, 32'hDEAD_BEEF},
            {32'h0000_0002, 32'hFFFF_FFFE},
            {32'h0000_03E8, 32'hFFFF_FC18},
            {32'h0000_0000, 32'h0100_0000},
            {32'h0000_0001, 32'h0000_0000},
            {32'h5555_5555, 32'hAAAA_AAAA}
        };
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            step_cmds.push_back({step_word(word_kind_e'($urandom_range(0, 3))),
                                 step_word(word_kind_e'($urandom_range(0, 3)))});
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        idx = 0;
        while (idx < step_cmds.size()) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && idx < step_cmds.size(); b++) begin
                send_cmd(step_cmds[idx]);
                idx++;
            end
            // some bursts run straight into the next one
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (beats_pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("fletcher16_cobs_frame_encoder_top verification clean");
        end else begin
            $display("fletcher16_cobs_frame_encoder_top verification failed");
        end
        $finish;
    end

endmodule
